@@ hdl/ptg_pkg.sv @@
// Shared types and constants for the proximity tone generator.
package ptg_pkg;

  // Fixed field and state widths
  localparam int DAC_BITS = 10;
  localparam int DIST_W   = 16;
  localparam int HP_W     = 10;
  localparam int FREQ_W   = 12;

  // Tone law constants
  localparam int DAC_MAX          = (1 << DAC_BITS) - 1;
  localparam int FREQ_MIN         = 500;
  localparam int FREQ_MAX         = 4000;
  localparam int FREQ_SPAN        = 3500;
  localparam int HALF_US_NUM      = 500000;
  localparam int HALF_RESET       = 500;
  localparam int MAX_RANGE_CM_DEF = 100;

  // Item kinds
  localparam logic KIND_DIST = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [DIST_W-1:0] distance;
  } ptg_in_t;

  typedef struct packed {
    logic [DAC_BITS-1:0] dac_level;
    logic                level_changed;
  } ptg_out_t;

  // Divider operand selection
  typedef enum logic [1:0] {
    DSEL_AMP = 2'd0,
    DSEL_FRQ = 2'd1,
    DSEL_HP  = 2'd2
  } ptg_div_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic         take_tick;
    logic         take_dist;
    logic         div_load;
    ptg_div_sel_t div_sel;
    logic         div_step;
    logic         store_amp;
    logic         store_freq;
    logic         store_half;
  } ptg_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic dist_in_range;
    logic div_busy;
  } ptg_status_t;

endpackage

@@ hdl/ptg_datapath.sv @@
// Datapath: tone state, tick counter, reciprocal multiply, restoring divider and result register.
module ptg_datapath #(
  parameter int MAX_RANGE_CM = ptg_pkg::MAX_RANGE_CM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ptg_pkg::ptg_in_t   in_data,
  input  ptg_pkg::ptg_cmd_t  cmd,
  output ptg_pkg::ptg_status_t status,
  output logic               out_valid,
  input  logic               out_ready,
  output ptg_pkg::ptg_out_t  out_data
);
  import ptg_pkg::*;

  localparam int DW      = $clog2(MAX_RANGE_CM + 1);
  localparam int PROD_W  = $clog2(MAX_RANGE_CM * FREQ_SPAN + 1);
  localparam int DIV_W   = (PROD_W > 20) ? PROD_W : 20;
  localparam int CNT_W   = $clog2(DIV_W + 1);

  // Reciprocal of the range: exact floor division for any dividend below 2**DIV_W
  localparam int                RCP_L = $clog2(MAX_RANGE_CM);
  localparam int                RCP_S = DIV_W + RCP_L;
  localparam longint unsigned   RCP_M = ((64'd1 << RCP_S) + 64'(MAX_RANGE_CM) - 64'd1) /
                                        64'(MAX_RANGE_CM);
  localparam int                RCP_W = DIV_W + 1;
  localparam int                PRD_W = DIV_W + RCP_W;

  // Architectural tone state
  logic                tone_en_r;
  logic [DAC_BITS-1:0] amp_r;
  logic [HP_W-1:0]     half_r;
  logic [HP_W-1:0]     cnt_r;
  logic                phase_r;
  logic [DAC_BITS-1:0] level_r;

  // Set-up operands
  logic [DW-1:0]       dist_r;
  logic [FREQ_W-1:0]   freq_r;

  // Divider
  logic [DIV_W-1:0]    quo_r;
  logic [FREQ_W-1:0]   rem_r;
  logic [FREQ_W-1:0]   dvsr_r;
  logic [CNT_W-1:0]    dcnt_r;

  // Result register
  logic                out_valid_r;
  ptg_out_t            out_data_r;

  // Tick evaluation
  logic [HP_W:0]       cnt_inc;
  logic                match;
  logic                phase_nxt;
  logic [DAC_BITS-1:0] level_nxt;

  // Divider step
  logic [FREQ_W:0]     shifted;
  logic [FREQ_W:0]     diff;
  logic [DIV_W-1:0]    dividend;
  logic [FREQ_W-1:0]   divisor;

  // Reciprocal multiply
  logic [PRD_W-1:0]    rcp_prod;
  logic [PRD_W-1:0]    rcp_quo;

  // Evaluate one tick against the half period
  always_comb begin
    cnt_inc   = {1'b0, cnt_r} + (HP_W+1)'(1);
    match     = cnt_inc >= {1'b0, half_r};
    phase_nxt = tone_en_r ? ~phase_r : phase_r;
    level_nxt = (tone_en_r && phase_nxt) ? amp_r : '0;
  end

  // Select divider operands
  always_comb begin
    case (cmd.div_sel)
      DSEL_AMP: begin
        dividend = DIV_W'(dist_r) * DIV_W'(DAC_MAX);
        divisor  = FREQ_W'(MAX_RANGE_CM);
      end
      DSEL_FRQ: begin
        dividend = (DIV_W'(MAX_RANGE_CM) - DIV_W'(dist_r)) * DIV_W'(FREQ_SPAN);
        divisor  = FREQ_W'(MAX_RANGE_CM);
      end
      DSEL_HP: begin
        dividend = DIV_W'(HALF_US_NUM);
        divisor  = freq_r;
      end
      default: begin
        dividend = '0;
        divisor  = FREQ_W'(MAX_RANGE_CM);
      end
    endcase
  end

  // Divide the loaded operand by the range
  always_comb begin
    rcp_prod = PRD_W'(quo_r) * PRD_W'(RCP_M);
    rcp_quo  = rcp_prod >> RCP_S;
  end

  // Trial subtract of one restoring step
  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    diff    = shifted - {1'b0, dvsr_r};
  end

  // Update tone state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_en_r <= 1'b0;
      amp_r     <= '0;
      half_r    <= HP_W'(HALF_RESET);
      cnt_r     <= '0;
      phase_r   <= 1'b0;
      level_r   <= '0;
    end else begin
      if (cmd.take_tick) begin
        if (match) begin
          cnt_r   <= '0;
          phase_r <= phase_nxt;
          level_r <= level_nxt;
        end else begin
          cnt_r <= cnt_inc[HP_W-1:0];
        end
      end
      if (cmd.take_dist) begin
        tone_en_r <= status.dist_in_range;
        if (!status.dist_in_range) begin
          amp_r <= '0;
        end
      end
      if (cmd.store_amp) begin
        amp_r <= DAC_BITS'(DAC_MAX) - rcp_quo[DAC_BITS-1:0];
      end
      if (cmd.store_half) begin
        half_r <= quo_r[HP_W-1:0];
      end
    end
  end

  // Capture set-up operands
  always_ff @(posedge clk) begin
    if (cmd.take_dist) begin
      dist_r <= in_data.distance[DW-1:0];
    end
    if (cmd.store_freq) begin
      freq_r <= FREQ_W'(FREQ_MIN) + rcp_quo[FREQ_W-1:0];
    end
  end

  // Run the divider one quotient bit per cycle; only the half period uses it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_load) begin
      dcnt_r <= (cmd.div_sel == DSEL_HP) ? CNT_W'(DIV_W) : '0;
    end else if (cmd.div_step && dcnt_r != '0) begin
      dcnt_r <= dcnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo_r  <= dividend;
      rem_r  <= '0;
      dvsr_r <= divisor;
    end else if (cmd.div_step && dcnt_r != '0) begin
      if (!diff[FREQ_W]) begin
        rem_r <= diff[FREQ_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[FREQ_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.take_tick || cmd.take_dist) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_tick) begin
      out_data_r.dac_level     <= match ? level_nxt : level_r;
      out_data_r.level_changed <= match;
    end else if (cmd.take_dist) begin
      out_data_r.dac_level     <= level_r;
      out_data_r.level_changed <= 1'b0;
    end
  end

  // Report status to the controller
  always_comb begin
    status.out_free      = !out_valid_r || out_ready;
    status.dist_in_range = in_data.distance <= DIST_W'(MAX_RANGE_CM);
    status.div_busy      = dcnt_r != '0;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/ptg_controller.sv @@
// Controller: accepts transactions and sequences the set-up steps.
module ptg_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ptg_pkg::ptg_in_t     in_data,
  input  ptg_pkg::ptg_status_t status,
  output ptg_pkg::ptg_cmd_t    cmd
);
  import ptg_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_AMP_LD  = 7'b0000010,
    ST_AMP_MUL = 7'b0000100,
    ST_FRQ_LD  = 7'b0001000,
    ST_FRQ_MUL = 7'b0010000,
    ST_HP_LD   = 7'b0100000,
    ST_HP_DIV  = 7'b1000000
  } ptg_state_t;

  ptg_state_t state_r;
  ptg_state_t state_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE) && status.out_free;
  assign accept   = in_valid && in_ready;

  // Decode commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.kind == KIND_TICK) begin
            cmd.take_tick = 1'b1;
          end else begin
            cmd.take_dist = 1'b1;
            if (status.dist_in_range) begin
              state_nxt = ST_AMP_LD;
            end
          end
        end
      end
      ST_AMP_LD: begin
        cmd.div_load = 1'b1;
        cmd.div_sel  = DSEL_AMP;
        state_nxt    = ST_AMP_MUL;
      end
      ST_AMP_MUL: begin
        cmd.store_amp = 1'b1;
        state_nxt     = ST_FRQ_LD;
      end
      ST_FRQ_LD: begin
        cmd.div_load = 1'b1;
        cmd.div_sel  = DSEL_FRQ;
        state_nxt    = ST_FRQ_MUL;
      end
      ST_FRQ_MUL: begin
        cmd.store_freq = 1'b1;
        state_nxt      = ST_HP_LD;
      end
      ST_HP_LD: begin
        cmd.div_load = 1'b1;
        cmd.div_sel  = DSEL_HP;
        state_nxt    = ST_HP_DIV;
      end
      ST_HP_DIV: begin
        if (status.div_busy) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.store_half = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/proximity_tone_generator.sv @@
// Top level of the proximity tone generator: controller plus datapath.
//
//   channel | dir | handshake           | payload
//   in_     | in  | in_valid / in_ready   | in_data  (kind, distance)
//   out_    | out | out_valid / out_ready | out_data (dac_level, level_changed)
//
// A tick is taken and its result is registered and shown the next cycle.
// A distance update posts its result the same way; an in-range distance then keeps
// the input closed until the set-up is done: two reciprocal multiplies give amplitude
// and frequency, then a restoring divider, one quotient bit per cycle, works out the
// half period. A waiting result holds the input only while out_ready is low. rst_n
// is synchronous: silent tone, half period 500.
module proximity_tone_generator #(
  parameter int MAX_RANGE_CM = ptg_pkg::MAX_RANGE_CM_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ptg_pkg::ptg_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ptg_pkg::ptg_out_t out_data
);
  import ptg_pkg::*;

  ptg_cmd_t    cmd;
  ptg_status_t status;

  ptg_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .status   (status),
    .cmd      (cmd)
  );

  ptg_datapath #(
    .MAX_RANGE_CM (MAX_RANGE_CM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
